@@ rtl/rfr_pkg.sv @@
// Package for the RFCOMM frame receiver: codes, frame constants, the result
// item type and the CRC-8 step function.
// Used by rfr_frame_core, rfr_out_buf and rfcomm_frame_receiver.
package rfr_pkg;

    // Receive credit window and the level at which credits are returned.
    localparam logic [2:0] RX_CREDIT_WINDOW = 3'd7;
    localparam logic [2:0] REPLENISH_LEVEL  = 3'd3;

    // Control field values with the P/F bit masked off.
    localparam logic [7:0] PF_MASK   = 8'hef;
    localparam logic [7:0] CTRL_SABM = 8'h2f;
    localparam logic [7:0] CTRL_UA   = 8'h63;
    localparam logic [7:0] CTRL_DM   = 8'h0f;
    localparam logic [7:0] CTRL_DISC = 8'h43;
    localparam logic [7:0] CTRL_UIH  = 8'hef;

    // CRC-8 constants, reflected form.
    localparam logic [7:0] CRC_POLY = 8'he0;
    localparam logic [7:0] CRC_INIT = 8'hff;

    // Saturation limits.
    localparam logic [7:0]  TX_CREDIT_MAX  = 8'd255;
    localparam logic [15:0] BYTE_COUNT_MAX = 16'hffff;

    // Result item kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_OVERRUN = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    // Frame type codes.
    localparam logic [2:0] FT_OTHER = 3'd0;
    localparam logic [2:0] FT_SABM  = 3'd1;
    localparam logic [2:0] FT_UA    = 3'd2;
    localparam logic [2:0] FT_DM    = 3'd3;
    localparam logic [2:0] FT_DISC  = 3'd4;
    localparam logic [2:0] FT_UIH   = 3'd5;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_CREDIT_FLOW  = 2'd0;
    localparam logic [1:0] REG_DATA_DLCI    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_OPEN = 2'd2;

    // Configuration as seen by the frame core.
    typedef struct packed {
        logic       credit_flow;
        logic [5:0] data_dlci;
        logic       channel_open;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  frame_status;
        logic [2:0]  frame_type;
        logic [5:0]  frame_dlci;
        logic [14:0] payload_length;
        logic [7:0]  credits_added;
        logic [7:0]  tx_credits;
        logic [2:0]  credit_return;
        logic [2:0]  rx_credits_left;
    } t_result;

    // One byte through the reflected CRC-8, LSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Frame type from the masked control field.
    function automatic logic [2:0] frame_type_of(input logic [7:0] ctrl);
        logic [2:0] t;
        case (ctrl)
            CTRL_SABM: t = FT_SABM;
            CTRL_UA:   t = FT_UA;
            CTRL_DM:   t = FT_DM;
            CTRL_DISC: t = FT_DISC;
            CTRL_UIH:  t = FT_UIH;
            default:   t = FT_OTHER;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/rfr_frame_core.sv @@
// Frame core of the RFCOMM receiver: per-byte header parsing, FCS, length
// check and credit accounting, all done in the cycle a byte is accepted.
// Depends on rfr_pkg.
module rfr_frame_core
    import rfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  t_cfg        i_cfg,
    output logic        o_res_valid,
    output t_result     o_res
);

    // Frame state, cleared after every last byte.
    logic [15:0] r_byte_count, n_byte_count;
    logic [7:0]  r_address, n_address;
    logic [7:0]  r_control, n_control;
    logic [14:0] r_length, n_length;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_credit_value, n_credit_value;
    logic        r_long, n_long;
    logic        r_credit_flag, n_credit_flag;
    // Credit counters, kept across frames.
    logic [2:0]  r_rx_credits, n_rx_credits;
    logic [7:0]  r_tx_credits, n_tx_credits;

    logic [7:0]  ctrl;
    logic [5:0]  dlci;
    logic [2:0]  offset;
    logic [15:0] start;
    logic [7:0]  crc_b;
    logic [16:0] frame_len;
    logic [16:0] expect_len;
    logic [2:0]  ftype;
    logic [2:0]  status;
    logic [8:0]  tx_sum;
    logic [2:0]  rx_after;

    always_comb begin
        ctrl       = r_control & PF_MASK;
        dlci       = r_address[7:2];
        offset     = r_long ? 3'd4 : 3'd3;
        start      = {13'd0, offset} + {15'd0, r_credit_flag};
        crc_b      = crc8_step(r_crc, i_data_byte);
        frame_len  = {1'b0, r_byte_count} + 17'd1;
        expect_len = {14'd0, offset} + {2'd0, r_length} + 17'd1 + {16'd0, r_credit_flag};
        ftype      = frame_type_of(ctrl);
        tx_sum     = {1'b0, r_tx_credits} + {1'b0, r_credit_value};
        rx_after   = r_rx_credits;
        status     = ST_OK;

        n_byte_count   = r_byte_count;
        n_address      = r_address;
        n_control      = r_control;
        n_length       = r_length;
        n_crc          = r_crc;
        n_credit_value = r_credit_value;
        n_long         = r_long;
        n_credit_flag  = r_credit_flag;
        n_rx_credits   = r_rx_credits;
        n_tx_credits   = r_tx_credits;

        o_res_valid                = 1'b0;
        o_res                      = '0;
        o_res.frame_dlci           = dlci;
        o_res.payload_length       = r_length;
        o_res.tx_credits           = r_tx_credits;
        o_res.rx_credits_left      = r_rx_credits;

        if (i_accept && !i_last_byte) begin
            // Header bytes.
            if (r_byte_count == 16'd0) begin
                n_address = i_data_byte;
                n_crc     = crc_b;
            end else if (r_byte_count == 16'd1) begin
                n_control     = i_data_byte;
                n_crc         = crc_b;
                n_credit_flag = ((i_data_byte & PF_MASK) == CTRL_UIH) &&
                                (r_address[7:2] != 6'd0) && i_cfg.credit_flow &&
                                i_data_byte[4];
            end else if (r_byte_count == 16'd2) begin
                n_length = {8'd0, i_data_byte[7:1]};
                n_long   = !i_data_byte[0];
                if (ctrl != CTRL_UIH) begin
                    n_crc = crc_b;
                end
            end else if (r_byte_count == 16'd3 && r_long) begin
                n_length = {i_data_byte, r_length[6:0]};
                if (ctrl != CTRL_UIH) begin
                    n_crc = crc_b;
                end
            end
            // Credit byte right after the length field.
            if (r_byte_count >= 16'd3 && r_byte_count == {13'd0, offset} && r_credit_flag) begin
                n_credit_value = i_data_byte;
            end
            if (r_byte_count != BYTE_COUNT_MAX) begin
                n_byte_count = r_byte_count + 16'd1;
            end
            // Information bytes of a UIH frame stream straight out.
            if (r_byte_count >= 16'd3 && ctrl == CTRL_UIH && r_byte_count >= start &&
                {1'b0, r_byte_count} < {1'b0, start} + {2'd0, r_length}) begin
                o_res_valid        = 1'b1;
                o_res.item_kind    = KIND_PAYLOAD;
                o_res.payload_byte = i_data_byte;
                o_res.frame_type   = FT_UIH;
            end
        end else if (i_accept) begin
            // Last byte: frame checks and credit accounting.
            if (r_byte_count < 16'd3 || !r_address[0] || (r_long && r_byte_count < 16'd4)) begin
                status = ST_SHORT;
            end else if (frame_len != expect_len || i_data_byte != ~r_crc) begin
                status = ST_BAD;
            end else if (ftype == FT_OTHER) begin
                status = ST_IGNORED;
            end else if (ftype == FT_UIH && dlci != 6'd0) begin
                if (dlci != i_cfg.data_dlci || !i_cfg.channel_open) begin
                    status = ST_IGNORED;
                end else begin
                    if (r_credit_flag) begin
                        n_tx_credits        = tx_sum[8] ? TX_CREDIT_MAX : tx_sum[7:0];
                        o_res.credits_added = r_credit_value;
                    end
                    if (r_length != 15'd0 && i_cfg.credit_flow) begin
                        if (r_rx_credits == 3'd0) begin
                            status = ST_OVERRUN;
                        end else begin
                            rx_after = r_rx_credits - 3'd1;
                        end
                    end
                    n_rx_credits = rx_after;
                    if (status == ST_OK && i_cfg.credit_flow && rx_after <= REPLENISH_LEVEL) begin
                        o_res.credit_return = RX_CREDIT_WINDOW - rx_after;
                        n_rx_credits        = RX_CREDIT_WINDOW;
                    end
                end
            end
            o_res_valid           = 1'b1;
            o_res.item_kind       = KIND_STATUS;
            o_res.frame_status    = status;
            o_res.frame_type      = ftype;
            o_res.tx_credits      = n_tx_credits;
            o_res.rx_credits_left = n_rx_credits;

            n_byte_count   = 16'd0;
            n_address      = 8'd0;
            n_control      = 8'd0;
            n_length       = 15'd0;
            n_crc          = CRC_INIT;
            n_credit_value = 8'd0;
            n_long         = 1'b0;
            n_credit_flag  = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= 16'd0;
            r_address      <= 8'd0;
            r_control      <= 8'd0;
            r_length       <= 15'd0;
            r_crc          <= CRC_INIT;
            r_credit_value <= 8'd0;
            r_long         <= 1'b0;
            r_credit_flag  <= 1'b0;
            r_rx_credits   <= RX_CREDIT_WINDOW;
            r_tx_credits   <= 8'd0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_address      <= n_address;
            r_control      <= n_control;
            r_length       <= n_length;
            r_crc          <= n_crc;
            r_credit_value <= n_credit_value;
            r_long         <= n_long;
            r_credit_flag  <= n_credit_flag;
            r_rx_credits   <= n_rx_credits;
            r_tx_credits   <= n_tx_credits;
        end
    end

`ifndef NO_ASSERTIONS
    // A last byte always leaves the frame state cleared.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_byte_count == 16'd0 && r_crc == CRC_INIT))
        else $error("frame state not cleared after last byte");
    // Receive credits never rise above the window.
    a_rx_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_credits <= RX_CREDIT_WINDOW)
        else $error("receive credits above window");
`endif

endmodule

@@ rtl/rfr_out_buf.sv @@
// Two-entry output buffer for result items: an output register and a skid
// register, so a new item is taken while a finished result waits.
// Depends on rfr_pkg.
module rfr_out_buf
    import rfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    out_fire;

    assign out_fire = r_main_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_res    = r_main;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_main_valid || out_fire) begin
            r_main_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_main <= r_skid;
            end
        end else if (!r_main_valid || out_fire) begin
            if (i_res_valid) begin
                r_main <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

`ifndef NO_ASSERTIONS
    // The skid register only holds an item behind a waiting output item.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid item without output item");
    // The skid register fills only while the output is stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_main_valid && i_stall))
        else $error("skid filled without stall");
    // A drained skid item moves to the output register.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_main_valid && !r_skid_valid))
        else $error("skid item lost on drain");
`endif

endmodule

@@ rtl/rfcomm_frame_receiver.sv @@
// Top level of the RFCOMM frame receiver: configuration registers on an
// APB-style port, the frame core and the output buffer.
// Depends on rfr_pkg, rfr_frame_core and rfr_out_buf.
//
// Usage: frame bytes enter on the input channel (i_in_valid / o_in_stall),
// one byte per item, with i_last_byte high on the FCS byte. Results leave on
// the output channel (o_out_valid / i_out_stall): one payload item for each
// information byte of a UIH frame, and one status item per frame on its last
// byte. Header, credit and surplus bytes give no result.
// A byte is accepted every cycle while o_in_stall is low; its result goes
// into the output register. The per-byte work (CRC step, counters, length
// and FCS compare, credit update) sits between the frame state registers
// and the output register. When the output stalls, one more result is held
// in a skid register; o_in_stall rises only while that register is occupied.
// Synchronous reset clears the frame state, sets receive credits to seven and
// transmit credits to zero, and clears the configuration registers. The user
// must write configuration only while no frame is in progress; the block does not enforce it.
module rfcomm_frame_receiver
    import rfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_frame_status,
    output logic [2:0]  o_frame_type,
    output logic [5:0]  o_frame_dlci,
    output logic [14:0] o_payload_length,
    output logic [7:0]  o_credits_added,
    output logic [7:0]  o_tx_credits,
    output logic [2:0]  o_credit_return,
    output logic [2:0]  o_rx_credits_left
);

    logic       r_credit_flow;
    logic [5:0] r_data_dlci;
    logic       r_channel_open;
    logic       cfg_write;
    logic       in_accept;
    logic       buf_full;
    logic       res_valid;
    t_cfg       cfg;
    t_result    res;
    t_result    out_res;

    // Configuration writes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit_flow  <= 1'b0;
            r_data_dlci    <= 6'd0;
            r_channel_open <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_CREDIT_FLOW:  r_credit_flow  <= pwdata[0];
                REG_DATA_DLCI:    r_data_dlci    <= pwdata[5:0];
                REG_CHANNEL_OPEN: r_channel_open <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        case (paddr[3:2])
            REG_CREDIT_FLOW:  prdata = {31'd0, r_credit_flow};
            REG_DATA_DLCI:    prdata = {26'd0, r_data_dlci};
            REG_CHANNEL_OPEN: prdata = {31'd0, r_channel_open};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.credit_flow  = r_credit_flow;
    assign cfg.data_dlci    = r_data_dlci;
    assign cfg.channel_open = r_channel_open;

    // Input handshake.
    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    rfr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .i_stall     (i_out_stall)
    );

    // Result fields.
    assign o_item_kind       = out_res.item_kind;
    assign o_payload_byte    = out_res.payload_byte;
    assign o_frame_status    = out_res.frame_status;
    assign o_frame_type      = out_res.frame_type;
    assign o_frame_dlci      = out_res.frame_dlci;
    assign o_payload_length  = out_res.payload_length;
    assign o_credits_added   = out_res.credits_added;
    assign o_tx_credits      = out_res.tx_credits;
    assign o_credit_return   = out_res.credit_return;
    assign o_rx_credits_left = out_res.rx_credits_left;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the RFCOMM frame receiver: drives byte streams of
// well-formed, damaged and noise frames, and checks every result item.
// Depends on rfr_pkg and rfcomm_frame_receiver.
module testbench
    import rfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_BYTES_PER_PHASE = 225;

    // One input item: a frame byte and its last-byte flag.
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_rx_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_item_kind;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_frame_status;
    logic [2:0]  o_frame_type;
    logic [5:0]  o_frame_dlci;
    logic [14:0] o_payload_length;
    logic [7:0]  o_credits_added;
    logic [7:0]  o_tx_credits;
    logic [2:0]  o_credit_return;
    logic [2:0]  o_rx_credits_left;

    rfcomm_frame_receiver uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_item_kind       (o_item_kind),
        .o_payload_byte    (o_payload_byte),
        .o_frame_status    (o_frame_status),
        .o_frame_type      (o_frame_type),
        .o_frame_dlci      (o_frame_dlci),
        .o_payload_length  (o_payload_length),
        .o_credits_added   (o_credits_added),
        .o_tx_credits      (o_tx_credits),
        .o_credit_return   (o_credit_return),
        .o_rx_credits_left (o_rx_credits_left)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bytes waiting to be sent and result items waiting to arrive.
    t_rx_byte pending_bytes[$];
    t_result  expected_items[$];
    int       queued_count = 0;
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       send_gap = 0;
    int       recv_hold = 0;

    // Configuration as last written.
    logic       cfg_credit_flow = 1'b0;
    logic [5:0] cfg_data_dlci = '0;
    logic       cfg_channel_open = 1'b0;

    // Frame parser state of the predictor; cleared after every last byte.
    logic [15:0] fr_count = '0;
    logic [7:0]  fr_addr = '0;
    logic [7:0]  fr_ctrl = '0;
    logic [14:0] fr_len = '0;
    logic [7:0]  fr_crc = CRC_INIT;
    logic [7:0]  fr_credit = '0;
    logic        fr_two_byte_len = 1'b0;
    logic        fr_has_credit = 1'b0;

    // Credit counters; these persist across frames.
    logic [2:0]  rx_credit_count = RX_CREDIT_WINDOW;
    logic [7:0]  tx_credit_count = '0;

    // Reflected CRC-8, one byte, least significant bit first.
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [2:0] classify_control(input logic [7:0] ctrl_m);
        case (ctrl_m)
            CTRL_SABM: return FT_SABM;
            CTRL_UA:   return FT_UA;
            CTRL_DM:   return FT_DM;
            CTRL_DISC: return FT_DISC;
            CTRL_UIH:  return FT_UIH;
            default:   return FT_OTHER;
        endcase
    endfunction

    // Work out the result items caused by one accepted byte.
    task automatic predict_frame_byte(input logic [7:0] b, input logic is_last);
        t_result    r;
        int         pos;
        int         offset;
        int         start;
        int         n;
        int         sum;
        logic [7:0] ctrl_m;
        logic [5:0] dlci;
        logic [2:0] ftype;

        pos = fr_count;
        ctrl_m = fr_ctrl & PF_MASK;
        dlci = fr_addr[7:2];
        offset = fr_two_byte_len ? 4 : 3;
        r = '0;
        r.frame_dlci = dlci;

        if (!is_last) begin
            // Header bytes: address and control always feed the FCS, the
            // length bytes only for frames other than UIH.
            if (pos == 0) begin
                fr_addr = b;
                fr_crc = crc8_next(fr_crc, b);
            end else if (pos == 1) begin
                fr_ctrl = b;
                fr_crc = crc8_next(fr_crc, b);
                fr_has_credit = ((b & PF_MASK) == CTRL_UIH) && (fr_addr[7:2] != 6'd0) &&
                                cfg_credit_flow && b[4];
            end else if (pos == 2) begin
                fr_len = {8'd0, b[7:1]};
                fr_two_byte_len = !b[0];
                if (ctrl_m != CTRL_UIH) fr_crc = crc8_next(fr_crc, b);
            end else if (pos == 3 && fr_two_byte_len) begin
                fr_len = {b, fr_len[6:0]};
                if (ctrl_m != CTRL_UIH) fr_crc = crc8_next(fr_crc, b);
            end
            if (pos >= 3 && pos == offset && fr_has_credit) fr_credit = b;
            if (fr_count != BYTE_COUNT_MAX) fr_count = fr_count + 16'd1;

            // Information bytes of a UIH frame stream straight out.
            start = offset + (fr_has_credit ? 1 : 0);
            if (pos >= 3 && ctrl_m == CTRL_UIH && pos >= start && pos < start + int'(fr_len)) begin
                r.item_kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.frame_status = ST_OK;
                r.frame_type = FT_UIH;
                r.payload_length = fr_len;
                r.tx_credits = tx_credit_count;
                r.rx_credits_left = rx_credit_count;
                expected_items.push_back(r);
            end
        end else begin
            // FCS byte: one status item for the whole frame.
            n = pos + 1;
            ftype = classify_control(ctrl_m);
            r.item_kind = KIND_STATUS;
            r.frame_type = ftype;
            r.payload_length = fr_len;
            r.frame_status = ST_OK;
            if (n < 4 || !fr_addr[0] || (fr_two_byte_len && n < 5)) begin
                r.frame_status = ST_SHORT;
            end else if (n != offset + int'(fr_len) + 1 + (fr_has_credit ? 1 : 0) ||
                         b != ~fr_crc) begin
                r.frame_status = ST_BAD;
            end else if (ftype == FT_OTHER) begin
                r.frame_status = ST_IGNORED;
            end else if (ftype == FT_UIH && dlci != 6'd0) begin
                if (dlci != cfg_data_dlci || !cfg_channel_open) begin
                    r.frame_status = ST_IGNORED;
                end else begin
                    // Data channel: take granted credits, spend one for payload.
                    if (fr_has_credit) begin
                        sum = int'(tx_credit_count) + int'(fr_credit);
                        tx_credit_count = (sum > 255) ? TX_CREDIT_MAX : sum[7:0];
                        r.credits_added = fr_credit;
                    end
                    if (fr_len != 0 && cfg_credit_flow) begin
                        if (rx_credit_count == 0) r.frame_status = ST_OVERRUN;
                        else rx_credit_count = rx_credit_count - 3'd1;
                    end
                    if (r.frame_status == ST_OK && cfg_credit_flow &&
                        rx_credit_count <= REPLENISH_LEVEL) begin
                        r.credit_return = RX_CREDIT_WINDOW - rx_credit_count;
                        rx_credit_count = RX_CREDIT_WINDOW;
                    end
                end
            end
            r.tx_credits = tx_credit_count;
            r.rx_credits_left = rx_credit_count;
            expected_items.push_back(r);

            fr_count = '0;
            fr_addr = '0;
            fr_ctrl = '0;
            fr_len = '0;
            fr_crc = CRC_INIT;
            fr_credit = '0;
            fr_two_byte_len = 1'b0;
            fr_has_credit = 1'b0;
        end
    endtask

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one received result item with the oldest expected one.
    task automatic check_result();
        t_result got;
        t_result want;
        string   diffs;

        got = {o_item_kind, o_payload_byte, o_frame_status, o_frame_type, o_frame_dlci,
               o_payload_length, o_credits_added, o_tx_credits, o_credit_return,
               o_rx_credits_left};
        if (expected_items.size() == 0) begin
            note_mismatch($sformatf("unexpected result item, kind %0d byte %0d status %0d",
                                    got.item_kind, got.payload_byte, got.frame_status));
            return;
        end
        want = expected_items.pop_front();
        diffs = "";
        if (got.item_kind !== want.item_kind)
            diffs = {diffs, $sformatf(" kind exp %0d got %0d", want.item_kind, got.item_kind)};
        if (got.payload_byte !== want.payload_byte)
            diffs = {diffs, $sformatf(" byte exp %0d got %0d", want.payload_byte,
                                      got.payload_byte)};
        if (got.frame_status !== want.frame_status)
            diffs = {diffs, $sformatf(" status exp %0d got %0d", want.frame_status,
                                      got.frame_status)};
        if (got.frame_type !== want.frame_type)
            diffs = {diffs, $sformatf(" type exp %0d got %0d", want.frame_type, got.frame_type)};
        if (got.frame_dlci !== want.frame_dlci)
            diffs = {diffs, $sformatf(" dlci exp %0d got %0d", want.frame_dlci, got.frame_dlci)};
        if (got.payload_length !== want.payload_length)
            diffs = {diffs, $sformatf(" length exp %0d got %0d", want.payload_length,
                                      got.payload_length)};
        if (got.credits_added !== want.credits_added)
            diffs = {diffs, $sformatf(" added exp %0d got %0d", want.credits_added,
                                      got.credits_added)};
        if (got.tx_credits !== want.tx_credits)
            diffs = {diffs, $sformatf(" tx exp %0d got %0d", want.tx_credits, got.tx_credits)};
        if (got.credit_return !== want.credit_return)
            diffs = {diffs, $sformatf(" return exp %0d got %0d", want.credit_return,
                                      got.credit_return)};
        if (got.rx_credits_left !== want.rx_credits_left)
            diffs = {diffs, $sformatf(" rx exp %0d got %0d", want.rx_credits_left,
                                      got.rx_credits_left)};
        if (diffs != "") note_mismatch(diffs);
    endtask

    // Input driver: send queued bytes with random gaps between items.
    always @(posedge i_clk) begin
        t_rx_byte next_byte;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_frame_byte(i_data_byte, i_last_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_byte = pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= next_byte.value;
                    i_last_byte <= next_byte.is_last;
                    send_gap = pick_gap(send_idle_pct);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check accepted items and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result();
            if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                recv_hold = pick_gap(recv_idle_pct);
            end
        end
    end

    // Count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("rfcomm_frame_receiver test failed");
        $finish;
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CREDIT_FLOW:  cfg_credit_flow = val[0];
            REG_DATA_DLCI:    cfg_data_dlci = val[5:0];
            REG_CHANNEL_OPEN: cfg_channel_open = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic mode, input logic [5:0] dlci, input logic open_ch);
        reg_write(REG_CREDIT_FLOW, {31'd0, mode});
        reg_write(REG_DATA_DLCI, {26'd0, dlci});
        reg_write(REG_CHANNEL_OPEN, {31'd0, open_ch});
    endtask

    // Block until every byte is sent and every result item has arrived.
    task automatic wait_for_idle();
        while (pending_bytes.size() != 0 || i_in_valid || expected_items.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void queue_byte(input logic [7:0] v, input logic is_last);
        t_rx_byte item;
        item.value = v;
        item.is_last = is_last;
        pending_bytes.push_back(item);
        queued_count++;
    endfunction

    // Build one frame; the credit byte appears where the current settings call for it.
    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] ctrl, input int plen,
                               input bit two_byte, input int body, input logic [7:0] credit,
                               input bit corrupt_fcs);
        logic [7:0]  hdr[$];
        logic [7:0]  crc;
        logic [14:0] len15;
        bit          uih;
        bit          has_credit;

        len15 = 15'(plen);
        uih = (ctrl & PF_MASK) == CTRL_UIH;
        has_credit = uih && addr[7:2] != 6'd0 && cfg_credit_flow && ctrl[4];
        hdr.push_back(addr);
        hdr.push_back(ctrl);
        if (two_byte) begin
            hdr.push_back({len15[6:0], 1'b0});
            hdr.push_back(len15[14:7]);
        end else begin
            hdr.push_back({len15[6:0], 1'b1});
        end
        crc = CRC_INIT;
        foreach (hdr[i]) begin
            if (i < 2 || !uih) crc = crc8_next(crc, hdr[i]);
            queue_byte(hdr[i], 1'b0);
        end
        if (has_credit) queue_byte(credit, 1'b0);
        repeat (body) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        if (corrupt_fcs) queue_byte(~crc ^ 8'($urandom_range(1, 255)), 1'b1);
        else queue_byte(~crc, 1'b1);
    endtask

    // Noise: random bytes ending in a last byte.
    task automatic queue_noise(input int n);
        repeat (n - 1) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Mostly well-formed frames aimed at the data channel, with some damage.
    task automatic queue_random_frame();
        int         pick;
        int         plen;
        int         body;
        int         fault;
        logic [5:0] dlci;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] credit;
        bit         two_byte;

        pick = $urandom_range(0, 99);
        if (pick < 60) dlci = cfg_data_dlci;
        else if (pick < 72) dlci = 6'd0;
        else dlci = 6'($urandom_range(0, 63));
        addr = {dlci, 1'b0, 1'b1};
        addr[1] = 1'($urandom_range(0, 1));

        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            ctrl = CTRL_UIH;
            ctrl[4] = ($urandom_range(0, 3) != 0);
        end else if (pick < 95) begin
            case ($urandom_range(0, 3))
                0: ctrl = CTRL_SABM;
                1: ctrl = CTRL_UA;
                2: ctrl = CTRL_DM;
                default: ctrl = CTRL_DISC;
            endcase
            ctrl[4] = 1'($urandom_range(0, 1));
        end else begin
            ctrl = 8'($urandom_range(0, 255));
        end

        pick = $urandom_range(0, 99);
        if (pick < 85) plen = $urandom_range(0, 10);
        else if (pick < 97) plen = $urandom_range(11, 127);
        else plen = $urandom_range(128, 400);
        two_byte = (plen > 127) || ($urandom_range(0, 9) == 0);
        credit = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
        body = plen;

        fault = $urandom_range(0, 99);
        if (fault < 6) begin
            queue_noise($urandom_range(1, 4));
        end else begin
            if (fault < 10) addr[0] = 1'b0;
            else if (fault < 14) body = (plen == 0 || $urandom_range(0, 1)) ? plen + 1 : plen - 1;
            queue_frame(addr, ctrl, plen, two_byte, body, credit, fault >= 14 && fault < 18);
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int first;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = queued_count;
        while (queued_count - first < RANDOM_BYTES_PER_PHASE) queue_random_frame();
        wait_for_idle();
    endtask

    // Stimulus: directed frames, then random phases under several settings.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(1'b1, 6'd5, 1'b1);
        send_idle_pct = 30;
        recv_idle_pct = 30;

        // Every frame type, each on the control or the data channel.
        queue_frame(8'h03, CTRL_SABM | 8'h10, 0, 0, 0, 8'h00, 0);
        queue_frame({6'd5, 2'b11}, CTRL_UA | 8'h10, 0, 0, 0, 8'h00, 0);
        queue_frame({6'd5, 2'b01}, CTRL_DM, 0, 0, 0, 8'h00, 0);
        queue_frame({6'd5, 2'b11}, CTRL_DISC | 8'h10, 0, 0, 0, 8'h00, 0);
        queue_frame(8'h03, CTRL_UIH, 2, 0, 2, 8'h00, 0);
        // Credit grants: the largest value fills the transmit credits, the next one saturates them.
        queue_frame({6'd5, 2'b01}, CTRL_UIH | 8'h10, 3, 0, 3, 8'hff, 0);
        queue_frame({6'd5, 2'b01}, CTRL_UIH | 8'h10, 1, 1, 1, 8'h01, 0);
        queue_frame({6'd5, 2'b01}, CTRL_UIH, 0, 0, 0, 8'h00, 0);
        // Two more payload frames drain receive credits to the refill level.
        queue_frame({6'd5, 2'b01}, CTRL_UIH, 1, 0, 1, 8'h00, 0);
        queue_frame({6'd5, 2'b01}, CTRL_UIH, 2, 0, 2, 8'h00, 0);
        // Unknown control value and UIH on a channel that is not the data channel.
        queue_frame({6'd5, 2'b01}, 8'h01, 0, 0, 0, 8'h00, 0);
        queue_frame({6'd9, 2'b01}, CTRL_UIH, 1, 0, 1, 8'h00, 0);
        // Short frames: too few bytes, no EA in the address, two-byte length cut off.
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h3f, 1'b0);
        queue_byte(8'h01, 1'b1);
        queue_frame(8'h02, CTRL_SABM, 0, 0, 0, 8'h00, 0);
        queue_byte(8'h03, 1'b0);
        queue_byte(CTRL_UIH, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b1);
        // Bad FCS, then a length that does not match the declared one.
        queue_frame(8'h03, CTRL_SABM, 0, 0, 0, 8'h00, 1);
        queue_frame({6'd5, 2'b01}, CTRL_UIH, 2, 0, 3, 8'h00, 0);
        // Largest declared length with a truncated body.
        queue_frame({6'd5, 2'b01}, CTRL_UIH, 32767, 1, 3, 8'h00, 0);
        wait_for_idle();

        run_random_phase(30, 30);
        configure(1'b0, 6'd63, 1'b1);
        run_random_phase(50, 10);
        configure(1'b1, 6'd0, 1'b1);
        run_random_phase(10, 50);
        configure(1'b1, 6'd1, 1'b0);
        run_random_phase(30, 30);
        configure(1'b1, 6'd42, 1'b1);
        run_random_phase(0, 0);
        configure(1'b0, 6'd0, 1'b0);
        run_random_phase(20, 20);

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_items.size() == 0) begin
            $display("rfcomm_frame_receiver test passed");
        end else begin
            $display("rfcomm_frame_receiver test failed");
        end
        $finish;
    end

endmodule
